// ===== rtl/pcmt_pkg.sv =====
// shared types, codes and constants for the priority command mux
`timescale 1ns / 1ps
package pcmt_pkg;

   localparam int MAX_SOURCES   = 4;
   localparam int SRC_W         = 2;
   localparam int PAYLOAD_W     = 64;
   localparam int CFG_TIMEOUT_W = 16;
   localparam int PRIO_W        = 8;
   localparam int COUNT_W       = 3;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // request and response bus widths
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 80;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SOURCE_COUNT = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRIORITY     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT0     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT1     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT2     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT3     = 3'd5;

   localparam logic [COUNT_W-1:0]       SOURCE_COUNT_RESET = 3'd4;
   localparam logic [CFG_TIMEOUT_W-1:0] TIMEOUT_RESET      = 16'd10;

   // request classification codes
   localparam logic [1:0] KIND_CMD     = 2'd0;
   localparam logic [1:0] KIND_TICK    = 2'd1;
   localparam logic [1:0] KIND_IGNORED = 2'd2;

   typedef struct packed {
      logic [1:0]           kind;
      logic [SRC_W-1:0]     source;
      logic [PAYLOAD_W-1:0] payload;
   } item_type;

   typedef struct packed {
      logic                 forward_valid;
      logic [PAYLOAD_W-1:0] forward_payload;
      logic                 owner_changed;
      logic                 owner_vacant;
      logic [SRC_W-1:0]     owner_index;
      logic [MAX_SOURCES-1:0] active_mask;
      logic                 ignored;
   } result_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] priority_table;
      logic [MAX_SOURCES-1:0][CFG_TIMEOUT_W-1:0] timeout;
   } back_cfg_type;

   function automatic logic [PRIO_W-1:0] prio_of(input logic [CSR_DATA_W-1:0] tbl,
                                                input logic [SRC_W-1:0] idx);
      prio_of = tbl[idx*PRIO_W +: PRIO_W];
   endfunction

endpackage

// ===== rtl/pcmt_front.sv =====
// front stage: takes requests and classifies them as command, tick or ignored
`timescale 1ns / 1ps
module pcmt_front
   import pcmt_pkg::*;
#(
   parameter int SOURCES = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic               in_tick,
   input  logic [SRC_W-1:0]   in_source,
   input  logic [PAYLOAD_W-1:0] in_payload,
   input  logic [COUNT_W-1:0] source_count,
   output logic               out_valid,
   input  logic               out_ready,
   output item_type           out_item
);

   localparam logic [COUNT_W-1:0] SRC_LIMIT = COUNT_W'(SOURCES);

   logic                 valid_ff, valid_in;
   item_type             item_ff, item_in;
   logic [COUNT_W-1:0]   limit;
   logic                 out_of_range;

   always_comb begin
      limit        = (source_count > SRC_LIMIT) ? SRC_LIMIT : source_count;
      out_of_range = ({1'b0, in_source} >= limit);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (out_ready) begin
         valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         valid_in        = 1'b1;
         item_in.source  = in_source;
         item_in.payload = in_payload;
         if (in_tick) begin
            item_in.kind = KIND_TICK;
         end else if (out_of_range) begin
            item_in.kind = KIND_IGNORED;
         end else begin
            item_in.kind = KIND_CMD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== rtl/pcmt_queue.sv =====
// short queue of classified requests between front and back
`timescale 1ns / 1ps
module pcmt_queue
   import pcmt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/pcmt_back.sv =====
// back stage: ownership, timeout counters and the response register
`timescale 1ns / 1ps
module pcmt_back
   import pcmt_pkg::*;
#(
   parameter int SOURCES      = 4,
   parameter int TIMEOUT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  back_cfg_type cfg,
   input  logic         in_valid,
   output logic         in_ready,
   input  item_type     in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output result_type   out_result
);

   localparam logic [TIMEOUT_BITS-1:0] ONE_TICK = TIMEOUT_BITS'(1);

   logic                    active_ff [SOURCES];
   logic                    active_in [SOURCES];
   logic [TIMEOUT_BITS-1:0] rem_ff    [SOURCES];
   logic [TIMEOUT_BITS-1:0] rem_in    [SOURCES];
   logic                    vacant_ff, vacant_in;
   logic [SRC_W-1:0]        owner_ff, owner_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;
   result_type              res;
   logic                    take;
   logic                    wins;

   assign in_ready   = !rsp_valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign out_valid  = rsp_valid_ff;
   assign out_result = rsp_ff;

   always_comb begin
      for (int i = 0; i < SOURCES; i++) begin
         active_in[i] = active_ff[i];
         rem_in[i]    = rem_ff[i];
      end
      vacant_in = vacant_ff;
      owner_in  = owner_ff;
      res       = '0;
      wins      = vacant_ff || (owner_ff == in_item.source) ||
                  (prio_of(cfg.priority_table, in_item.source) >
                   prio_of(cfg.priority_table, owner_ff));

      case (in_item.kind)
         KIND_TICK: begin
            for (int i = 0; i < SOURCES; i++) begin
               if (active_ff[i]) begin
                  if (rem_ff[i] <= ONE_TICK) begin
                     rem_in[i]    = '0;
                     active_in[i] = 1'b0;
                     if (!vacant_ff && owner_ff == SRC_W'(i)) begin
                        vacant_in         = 1'b1;
                        res.owner_changed = 1'b1;
                     end
                  end else begin
                     rem_in[i] = rem_ff[i] - ONE_TICK;
                  end
               end
            end
         end
         KIND_CMD: begin
            for (int i = 0; i < SOURCES; i++) begin
               if (in_item.source == SRC_W'(i)) begin
                  rem_in[i]    = TIMEOUT_BITS'(cfg.timeout[i]);
                  active_in[i] = 1'b1;
               end
            end
            if (wins) begin
               if (vacant_ff || owner_ff != in_item.source) begin
                  res.owner_changed = 1'b1;
               end
               vacant_in           = 1'b0;
               owner_in            = in_item.source;
               res.forward_valid   = 1'b1;
               res.forward_payload = in_item.payload;
            end
         end
         KIND_IGNORED: begin
            res.ignored = 1'b1;
         end
         default: begin
            res.ignored = 1'b0;
         end
      endcase

      res.owner_vacant = vacant_in;
      res.owner_index  = vacant_in ? '0 : owner_in;
      for (int i = 0; i < SOURCES; i++) begin
         res.active_mask[i] = active_in[i];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SOURCES; i++) begin
            active_ff[i] <= 1'b0;
            rem_ff[i]    <= '0;
         end
         vacant_ff    <= 1'b1;
         owner_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            for (int i = 0; i < SOURCES; i++) begin
               active_ff[i] <= active_in[i];
               rem_ff[i]    <= rem_in[i];
            end
            vacant_ff <= vacant_in;
            owner_ff  <= owner_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

// ===== rtl/priority_command_mux_timeout.sv =====
// top level: priority command mux with per-source timeout
//
//  channel  | dir | handshake             | content
//  req      | in  | req_tvalid/req_tready | tuser: tick; tdata: source, payload
//  rsp      | out | rsp_tvalid/rsp_tready | tuser: forward_valid; tdata: result
//  csr      | in  | csr_wen               | csr_addr selects register, csr_wdata
//
// one request per cycle sustained while rsp is not stalled; rsp_tvalid rises once the request
// has passed the front register, then a queue entry, then the response register
// the ownership and counter update is one compare and decrement in the back stage
// synchronous reset: all sources inactive, owner vacant, registers at defaults
// a stalled rsp fills the two-entry queue before req_tready drops
`timescale 1ns / 1ps
module priority_command_mux_timeout
   import pcmt_pkg::*;
#(
   parameter int SOURCES      = 4,
   parameter int TIMEOUT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // source[1:0], payload[65:2], zero pad
   input  logic                  req_tuser,   // tick
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // forward_payload[63:0], owner_changed[64], owner_vacant[65], owner_index[67:66],
   // active_mask[71:68], ignored[72], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // forward_valid
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int RES_BITS = PAYLOAD_W + 1 + 1 + SRC_W + MAX_SOURCES + 1;

   logic [COUNT_W-1:0] source_count_ff;
   back_cfg_type       cfg_ff;

   logic       fq_valid, fq_ready;
   item_type   fq_item;
   logic       qb_valid, qb_ready;
   item_type   qb_item;
   result_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_count_ff    <= SOURCE_COUNT_RESET;
         cfg_ff.priority_table <= '0;
         for (int i = 0; i < MAX_SOURCES; i++) begin
            cfg_ff.timeout[i] <= TIMEOUT_RESET;
         end
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_SOURCE_COUNT: source_count_ff       <= csr_wdata[COUNT_W-1:0];
            CSR_PRIORITY:     cfg_ff.priority_table <= csr_wdata;
            CSR_TIMEOUT0:     cfg_ff.timeout[0]     <= csr_wdata[CFG_TIMEOUT_W-1:0];
            CSR_TIMEOUT1:     cfg_ff.timeout[1]     <= csr_wdata[CFG_TIMEOUT_W-1:0];
            CSR_TIMEOUT2:     cfg_ff.timeout[2]     <= csr_wdata[CFG_TIMEOUT_W-1:0];
            CSR_TIMEOUT3:     cfg_ff.timeout[3]     <= csr_wdata[CFG_TIMEOUT_W-1:0];
            default: begin
               source_count_ff <= source_count_ff;
            end
         endcase
      end
   end

   pcmt_front #(
      .SOURCES (SOURCES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_tick      (req_tuser),
      .in_source    (req_tdata[SRC_W-1:0]),
      .in_payload   (req_tdata[SRC_W +: PAYLOAD_W]),
      .source_count (source_count_ff),
      .out_valid    (fq_valid),
      .out_ready    (fq_ready),
      .out_item     (fq_item)
   );

   pcmt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   pcmt_back #(
      .SOURCES      (SOURCES),
      .TIMEOUT_BITS (TIMEOUT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (qb_valid),
      .in_ready   (qb_ready),
      .in_item    (qb_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tuser = result.forward_valid;
   assign rsp_tdata = {{(RSP_DATA_W - RES_BITS){1'b0}},
                       result.ignored,
                       result.active_mask,
                       result.owner_index,
                       result.owner_vacant,
                       result.owner_changed,
                       result.forward_payload};

endmodule
